@@ rtl/slb_pkg.sv @@
package slb_pkg;

  // Buffer geometry
  localparam int unsigned BUF_DEPTH = 64;
  localparam int unsigned CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int unsigned ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  // Word field widths
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned EXT_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned SUM_W   = EXT_W + 1;

  // Idle counter
  localparam int unsigned IDLE_W       = 17;
  localparam int unsigned TIMEOUT_W    = 16;
  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(50);

  // Control characters
  localparam logic [BYTE_W-1:0] CH_LF = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR = 8'd13;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = TIMEOUT_W;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_RX    = 3'd0,
    CMD_TICK  = 3'd1,
    CMD_READ  = 3'd2,
    CMD_PEEK  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] rx_byte;
    logic [POS_W-1:0]  peek_offset;
  } slb_in_t;

  typedef struct packed {
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              rx_accepted;
    logic              msg_done;
    logic              overflowed;
    logic [POS_W-1:0]  fill_length;
    logic [POS_W-1:0]  cursor;
  } slb_out_t;

endpackage

@@ rtl/slb_in_if.sv @@
interface slb_in_if;
  import slb_pkg::*;

  logic    valid;
  logic    ready;
  slb_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/slb_out_if.sv @@
interface slb_out_if;
  import slb_pkg::*;

  logic     valid;
  logic     ready;
  slb_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/serial_line_buffer.sv @@
// Pipeline: an accepted word's status is registered in the middle stage along with
// the store read, and both are merged into the output register when that stage moves on.
// Throughput: one word per cycle; the result word waits in an output register
// while the stage before it and the input keep moving as long as it is free.
// Reset: text mode on, idle timeout 50, buffer empty, flags clear; store
// contents are undefined and only written entries are ever read.
module serial_line_buffer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  slb_in_if.sink                         req_i,
  slb_out_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic [slb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [slb_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import slb_pkg::*;

  // Configuration and buffer state
  logic                 text_q, text_d;
  logic [TIMEOUT_W-1:0] timeout_q, timeout_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [IDLE_W-1:0]    idle_q, idle_d;
  logic                 done_q, done_d;
  logic                 ovf_q, ovf_d;

  // Middle stage (status waiting for read data) and output stage
  logic     s2_valid_q;
  slb_out_t s2_q, s2_d;
  logic     out_valid_q;
  slb_out_t out_q, out_d;

  logic              acc;
  logic              s2_adv;
  logic              hit;
  logic              rx_ok;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [IDLE_W-1:0] idle_inc;
  logic [SUM_W-1:0]  peek_sum;
  logic [EXT_W-1:0]  fill_ext;
  logic [EXT_W-1:0]  pos_ext;

  // Handshake: take a word whenever the middle stage is empty or moving on
  assign s2_adv      = s2_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s2_valid_q || s2_adv;
  assign acc         = req_i.valid && req_i.ready;

  assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + IDLE_W'(1);
  assign peek_sum = SUM_W'(pos_q) + SUM_W'(req_i.data.peek_offset);

  // Command decode and state update
  always_comb begin
    text_d    = text_q;
    timeout_d = timeout_q;
    count_d   = count_q;
    pos_d     = pos_q;
    idle_d    = idle_q;
    done_d    = done_q;
    ovf_d     = ovf_q;
    hit       = 1'b0;
    rx_ok     = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = pos_q[ADDR_W-1:0];

    if (acc) begin
      unique case (req_i.data.command)
        CMD_RX: begin
          if (!done_q) begin
            rx_ok  = 1'b1;
            idle_d = '0;
            if (text_q && req_i.data.rx_byte == CH_LF) begin
              // line feed is dropped
            end else if (text_q && req_i.data.rx_byte == CH_CR) begin
              done_d = 1'b1;
            end else if (count_q < CNT_W'(BUF_DEPTH)) begin
              ram_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        CMD_TICK: begin
          if (!done_q) begin
            idle_d = idle_inc;
            if (!text_q && count_q != '0 && idle_inc > IDLE_W'(timeout_q)) begin
              done_d = 1'b1;
            end
          end
        end
        CMD_READ: begin
          if (pos_q < count_q) begin
            hit   = 1'b1;
            pos_d = pos_q + CNT_W'(1);
          end
        end
        CMD_PEEK: begin
          if (peek_sum < SUM_W'(count_q)) begin
            hit       = 1'b1;
            ram_raddr = peek_sum[ADDR_W-1:0];
          end
        end
        CMD_CLEAR: begin
          count_d = '0;
          pos_d   = '0;
          idle_d  = '0;
          done_d  = 1'b0;
          ovf_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // Register writes; a mode write also clears the buffer
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TEXT_MODE: begin
          text_d  = cfg_wdata_i[0];
          count_d = '0;
          pos_d   = '0;
          idle_d  = '0;
          done_d  = 1'b0;
          ovf_d   = 1'b0;
        end
        REG_IDLE_TIMEOUT: begin
          timeout_d = cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Status of the word after its update
  assign fill_ext = EXT_W'(count_d);
  assign pos_ext  = EXT_W'(pos_d);

  always_comb begin
    s2_d             = '0;
    s2_d.data_valid  = hit;
    s2_d.rx_accepted = rx_ok;
    s2_d.msg_done    = done_d;
    s2_d.overflowed  = ovf_d;
    s2_d.fill_length = fill_ext[POS_W-1:0];
    s2_d.cursor      = pos_ext[POS_W-1:0];
  end

  // Merge the read data into the waiting status word
  always_comb begin
    out_d           = s2_q;
    out_d.data_byte = s2_q.data_valid ? ram_rdata : '0;
  end

  // Message store
  slb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (req_i.data.rx_byte),
    .re_i    (acc),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Buffer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q    <= 1'b1;
      timeout_q <= TIMEOUT_RST;
      count_q   <= '0;
      pos_q     <= '0;
      idle_q    <= '0;
      done_q    <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      text_q    <= text_d;
      timeout_q <= timeout_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      idle_q    <= idle_d;
      done_q    <= done_d;
      ovf_q     <= ovf_d;
    end
  end

  // Advance the middle and output stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s2_q <= s2_d;
    end
    if (s2_adv) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // Fill never passes capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(BUF_DEPTH))
    else $error("fill count beyond buffer depth");

  // Cursor never passes the fill
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= count_q)
    else $error("read cursor beyond fill count");

  // A finished message stays finished until a clear or a mode write
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !cfg_we_i && !(acc && req_i.data.command == CMD_CLEAR)) |=> done_q)
    else $error("message end flag dropped without clear");

  // Nothing is stored once the message has ended
  a_no_store_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !cfg_we_i) |=> count_q <= $past(count_q))
    else $error("byte stored after message end");

endmodule

@@ rtl/slb_ram.sv @@
module slb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
